[rtl/sfcd_pkg.sv]
// ----------------------------------------------------------------------------
// sfcd_pkg: shared types and constants of the sensor frame deframer
// Holds the queue entry format, the operation and verdict codes and the
// CRC-8 byte update used by the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcd_pkg;

    localparam int SENSOR_COUNT_DEF = 16;
    localparam int MAX_PAYLOAD      = 32;
    localparam int MAX_PAIRS        = MAX_PAYLOAD / 2;
    localparam logic [7:0] CRC_POLY = 8'h07;

    // Register map (word index)
    localparam logic REG_OK_STATUS = 1'b0;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_START = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        VERDICT_STORED    = 2'd0,
        VERDICT_NOT_STORED = 2'd1,
        VERDICT_LEN_ERROR = 2'd2,
        VERDICT_CRC_ERROR = 2'd3
    } verdict_t;

    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_READ    = 1'b1
    } kind_t;

    // One classified beat waiting between the front and the back end.
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [3:0] channel;
    } cmd_t;

    // CRC-8, MSB first, one byte per call.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/sfcd_front.sv]
// ----------------------------------------------------------------------------
// sfcd_front: input classification and command queue
// Sorts each accepted beat into a read, a frame start or a frame byte and
// holds it in a two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcd_front
    import sfcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] rx_byte, [11:8] channel, zero fill
    input  wire logic [1:0]  s_tuser,   // [0] func, [1] frame_start
    output logic             q_valid,
    output cmd_t             q_cmd,
    input  wire logic        q_pop
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       in_cmd;
    logic       push;

    always_comb
    begin
        in_cmd.data    = s_tdata[7:0];
        in_cmd.channel = s_tdata[11:8];
        priority if (s_tuser[0])
            in_cmd.op = OP_READ;
        else if (s_tuser[1])
            in_cmd.op = OP_START;
        else
            in_cmd.op = OP_BYTE;
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

`default_nettype wire

[rtl/sfcd_back.sv]
// ----------------------------------------------------------------------------
// sfcd_back: frame parser, sensor store and result register
// Runs the frame byte counter and CRC, stages payload pairs in a shadow
// store, commits them on a good frame and answers channel reads.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcd_back
    import sfcd_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  ok_status_code,
    input  wire logic        q_valid,
    input  wire cmd_t        q_cmd,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,
    output logic             m_tuser
);

    // Only sixteen pairs fit in a maximum payload, so no more lanes are needed.
    localparam int STORE_DEPTH = (SENSOR_COUNT < MAX_PAIRS) ? SENSOR_COUNT : MAX_PAIRS;

    logic [5:0]  pos_reg, pos_next;
    logic        dropped_reg, dropped_next;
    logic [7:0]  status_reg, status_next;
    logic [5:0]  len_reg, len_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  low_byte_reg;
    logic [15:0] store_reg  [STORE_DEPTH];
    logic [15:0] shadow_reg [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] pending_reg, pending_next;

    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg, out_kind_next;
    verdict_t    out_verdict_reg, out_verdict_next;
    logic [7:0]  out_status_reg, out_status_next;
    logic [7:0]  out_len_reg, out_len_next;
    logic [15:0] out_value_reg, out_value_next;

    logic        low_wr;
    logic        pair_wr;
    logic        commit;
    logic        emit;
    logic [5:0]  payload_idx;
    logic [3:0]  pair_idx;
    logic [15:0] read_value;

    assign q_pop       = q_valid && (!out_valid_reg || m_tready);
    assign payload_idx = pos_reg - 6'd2;
    assign pair_idx    = payload_idx[4:1];

    always_comb
    begin
        read_value = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (q_cmd.channel == 4'(i))
                read_value = store_reg[i];
        end
    end

    // Parser next state and result selection.
    always_comb
    begin
        pos_next         = pos_reg;
        dropped_next     = dropped_reg;
        status_next      = status_reg;
        len_next         = len_reg;
        crc_next         = crc_reg;
        pending_next     = pending_reg;
        low_wr           = 1'b0;
        pair_wr          = 1'b0;
        commit           = 1'b0;
        emit             = 1'b0;
        out_kind_next    = KIND_VERDICT;
        out_verdict_next = VERDICT_STORED;
        out_status_next  = 8'd0;
        out_len_next     = 8'd0;
        out_value_next   = 16'd0;

        if (q_pop)
        begin
            unique case (q_cmd.op)
                OP_READ:
                begin
                    emit           = 1'b1;
                    out_kind_next  = KIND_READ;
                    out_value_next = read_value;
                end
                OP_START:
                begin
                    status_next  = q_cmd.data;
                    len_next     = 6'd0;
                    crc_next     = crc8_step(8'd0, q_cmd.data);
                    dropped_next = 1'b0;
                    pos_next     = 6'd1;
                    pending_next = '0;
                end
                OP_BYTE:
                begin
                    if (pos_reg == 6'd0 || dropped_reg)
                    begin
                        // Idle or dropped frame: the byte is ignored.
                    end
                    else if (pos_reg == 6'd1)
                    begin
                        if (q_cmd.data > 8'(MAX_PAYLOAD))
                        begin
                            emit             = 1'b1;
                            out_verdict_next = VERDICT_LEN_ERROR;
                            out_status_next  = status_reg;
                            out_len_next     = q_cmd.data;
                            dropped_next     = 1'b1;
                            pos_next         = 6'd0;
                        end
                        else
                        begin
                            len_next = q_cmd.data[5:0];
                            crc_next = crc8_step(crc_reg, q_cmd.data);
                            pos_next = 6'd2;
                        end
                    end
                    else if ({1'b0, pos_reg} < 7'd2 + {1'b0, len_reg})
                    begin
                        crc_next = crc8_step(crc_reg, q_cmd.data);
                        pos_next = pos_reg + 6'd1;
                        if (!payload_idx[0])
                            low_wr = 1'b1;
                        else
                        begin
                            pair_wr = 1'b1;
                            for (int i = 0; i < STORE_DEPTH; i++)
                            begin
                                if (pair_idx == 4'(i))
                                    pending_next[i] = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // Check byte closes the frame.
                        pos_next        = 6'd0;
                        emit            = 1'b1;
                        out_status_next = status_reg;
                        out_len_next    = {2'b00, len_reg};
                        if (q_cmd.data != crc_reg)
                            out_verdict_next = VERDICT_CRC_ERROR;
                        else if (status_reg == ok_status_code && len_reg >= 6'd2)
                        begin
                            out_verdict_next = VERDICT_STORED;
                            commit           = 1'b1;
                        end
                        else
                            out_verdict_next = VERDICT_NOT_STORED;
                    end
                end
                default:
                begin
                end
            endcase
        end

        priority if (q_pop && emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 6'd0;
            dropped_reg   <= 1'b0;
            status_reg    <= 8'd0;
            len_reg       <= 6'd0;
            crc_reg       <= 8'd0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STORE_DEPTH; i++)
                store_reg[i] <= 16'd0;
        end
        else
        begin
            pos_reg       <= pos_next;
            dropped_reg   <= dropped_next;
            status_reg    <= status_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                for (int i = 0; i < STORE_DEPTH; i++)
                begin
                    if (pending_reg[i])
                        store_reg[i] <= shadow_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (low_wr)
            low_byte_reg <= q_cmd.data;
        if (pair_wr)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                if (pair_idx == 4'(i))
                    shadow_reg[i] <= {q_cmd.data, low_byte_reg};
            end
        end
        if (q_pop && emit)
        begin
            out_kind_reg    <= out_kind_next;
            out_verdict_reg <= out_verdict_next;
            out_status_reg  <= out_status_next;
            out_len_reg     <= out_len_next;
            out_value_reg   <= out_value_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_value_reg, out_len_reg, out_status_reg, out_verdict_reg};

endmodule

`default_nettype wire

[rtl/sensor_frame_crc_deframer_core.sv]
// ----------------------------------------------------------------------------
// sensor_frame_crc_deframer_core: CRC-8 checked response frame parser
// A beat passes through the front-end queue and then the back-end result
// register before its result is presented; an output stall holds it there.
// Throughput: one beat per cycle while the output is not stalled.
// Reset (rst_n, asynchronous, active low) clears the parser, the queue, the
// sensor store and the ok status register; no clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

// The block is split into a front end and a back end with a short queue
// between them. The front end accepts a beat, decides whether it is a channel
// read, the start of a frame or an ordinary frame byte, and queues it. The
// back end owns all frame state: the byte position, the running CRC, the
// header fields and the sensor store. It takes one queued beat per cycle
// whenever its result register is free or being emptied, so a stalled
// output does not stop the input until the queue fills.
//
// Payload pairs are written into a shadow copy of the store as they arrive,
// with a pending bit per channel. On a frame with a good CRC, the ok status
// and at least one whole pair, the pending channels are copied into the
// sensor store together; other frames leave the store untouched.

module sensor_frame_crc_deframer_core
    import sfcd_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] rx_byte, [11:8] channel, zero fill
    input  wire logic [1:0]  s_tuser,   // [0] func, [1] frame_start
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [1:0] verdict, [9:2] device_status,
                                        // [17:10] payload_length,
                                        // [33:18] sensor_value, zero fill
    output logic             m_tuser    // [0] result_kind
);

    logic [7:0] ok_status_reg, ok_status_next;
    logic       q_valid;
    logic       q_pop;
    cmd_t       q_cmd;

    // Register file: a single word, the ok status code, at byte address 0.
    assign pready = 1'b1;

    always_comb
    begin
        ok_status_next = ok_status_reg;
        if (psel && penable && pwrite && paddr[2] == REG_OK_STATUS)
            ok_status_next = pwdata[7:0];
    end

    always_comb
    begin
        if (paddr[2] == REG_OK_STATUS)
            prdata = {24'd0, ok_status_reg};
        else
            prdata = 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ok_status_reg <= 8'd0;
        else
            ok_status_reg <= ok_status_next;
    end

    sfcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    sfcd_back #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ok_status_code (ok_status_reg),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule

`default_nettype wire
